// ===== src/vctp_pkg.sv =====
// Shared types and constants of the Vorbis comment tag parser.
package vctp_pkg;

  localparam int BufBytes = 4096;
  localparam int AddrW    = 12;
  localparam int SpaceW   = 13;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [1:0] RegBufCap   = 2'd0;
  localparam logic [1:0] RegGuardEn  = 2'd1;
  localparam logic [1:0] RegGuardLen = 2'd2;

  localparam logic [2:0] TagGenre  = 3'd0;
  localparam logic [2:0] TagTitle  = 3'd1;
  localparam logic [2:0] TagArtist = 3'd2;
  localparam logic [2:0] TagAlbum  = 3'd3;
  localparam logic [2:0] TagDate   = 3'd4;

  typedef enum logic [2:0] {
    PhVlen,
    PhVskip,
    PhCount,
    PhClen,
    PhBody,
    PhHalt
  } phase_e;

  typedef enum logic [2:0] {
    KindWrite = 3'd0,
    KindTag   = 3'd1,
    KindSpace = 3'd2,
    KindError = 3'd3,
    KindDone  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [SpaceW-1:0] cap_sat;
    logic              guard_en;
    logic [31:0]       guard_len;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  addr;
    logic [7:0]        data;
    logic [2:0]        tag;
    logic [AddrW-1:0]  voff;
    logic [SpaceW-1:0] vlen;
  } record_t;

  typedef struct packed {
    logic [1:0]       count;
    record_t [2:0]    rec;
  } bundle_t;

endpackage

// ===== src/vctp_if.sv =====
// Handshake interfaces for the header byte stream and the result records.
interface vctp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_req;

  modport source (output valid, byte_value, start_req, input ready);
  modport sink (input valid, byte_value, start_req, output ready);
endinterface

interface vctp_rec_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   record_kind;
  logic [vctp_pkg::AddrW-1:0]   buffer_address;
  logic [7:0]                   data_byte;
  logic [2:0]                   tag_id;
  logic [vctp_pkg::AddrW-1:0]   value_offset;
  logic [vctp_pkg::SpaceW-1:0]  value_length;
  logic                         last;

  modport source (output valid, record_kind, buffer_address, data_byte, tag_id,
                  value_offset, value_length, last, input ready);
  modport sink (input valid, record_kind, buffer_address, data_byte, tag_id,
                value_offset, value_length, last, output ready);
endinterface

// ===== src/vctp_front.sv =====
// Front end: accepts header bytes, runs the parse state and builds result bundles.
module vctp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  vctp_byte_if.sink         byte_in_i,
  input  vctp_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output vctp_pkg::bundle_t bundle_o
);
  import vctp_pkg::*;

  phase_e                 phase_q, phase_d, ph_e;
  logic [1:0]             idx_q, idx_d, idx_e;
  logic [31:0]            len_q, len_d, len_e;
  logic [31:0]            cnt_q, cnt_d, cnt_e;
  logic [31:0]            body_q, body_d, body_e;
  logic [5:0][7:0]        prefix_q, prefix_d, prefix_e;
  logic [2:0]             pos_q, pos_d, pos_e;
  logic [SpaceW-1:0]      space_q, space_d, space_e;
  logic [AddrW-1:0]       wptr_q, wptr_d, wptr_e;
  logic [AddrW-1:0]       cstart_q, cstart_d, cstart_e;
  logic                   storing_q, storing_d, storing_e;

  logic                   acc, start;
  logic [31:0]            len_word;
  logic                   len_done, body_last, guard_hit, fits, last_comment;
  logic [7:0]             lc [6];
  logic                   hit;
  logic [2:0]             hit_tag, hit_skip;
  logic                   closing;
  logic                   wr_v, fin_v, tail_v;
  record_t                wr_rec, fin_rec, tail_rec;
  logic [1:0]             n_slot;

  assign byte_in_i.ready = !q_full_i;
  assign acc   = byte_in_i.valid && byte_in_i.ready;
  assign start = byte_in_i.start_req;

  // A start request makes this byte see the state of a fresh header.
  assign ph_e      = start ? PhVlen : phase_q;
  assign idx_e     = start ? '0 : idx_q;
  assign len_e     = start ? '0 : len_q;
  assign cnt_e     = start ? '0 : cnt_q;
  assign body_e    = start ? '0 : body_q;
  assign prefix_e  = start ? '0 : prefix_q;
  assign pos_e     = start ? '0 : pos_q;
  assign space_e   = start ? cfg_i.cap_sat : space_q;
  assign wptr_e    = start ? '0 : wptr_q;
  assign cstart_e  = start ? '0 : cstart_q;
  assign storing_e = start ? 1'b0 : storing_q;

  assign len_word     = len_e | (32'(byte_in_i.byte_value) << {idx_e, 3'b000});
  assign len_done     = idx_e == 2'd3;
  assign body_last    = body_e == 32'd1;
  assign guard_hit    = cfg_i.guard_en && (len_word > cfg_i.guard_len);
  assign fits         = len_word <= 32'(space_e);
  assign last_comment = cnt_e == 32'd1;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lc[i] = (prefix_e[i] >= "A" && prefix_e[i] <= "Z") ? prefix_e[i] + 8'h20
                                                           : prefix_e[i];
    end
  end

  // Key match; a key counts only when the comment is longer than key plus separator.
  always_comb begin
    hit      = 1'b1;
    hit_tag  = TagGenre;
    hit_skip = 3'd6;
    if (len_e > 32'd6 && lc[0] == "g" && lc[1] == "e" && lc[2] == "n" &&
        lc[3] == "r" && lc[4] == "e") begin
      hit_tag  = TagGenre;
      hit_skip = 3'd6;
    end else if (len_e > 32'd6 && lc[0] == "t" && lc[1] == "i" && lc[2] == "t" &&
                 lc[3] == "l" && lc[4] == "e") begin
      hit_tag  = TagTitle;
      hit_skip = 3'd6;
    end else if (len_e > 32'd7 && lc[0] == "a" && lc[1] == "r" && lc[2] == "t" &&
                 lc[3] == "i" && lc[4] == "s" && lc[5] == "t") begin
      hit_tag  = TagArtist;
      hit_skip = 3'd7;
    end else if (len_e > 32'd6 && lc[0] == "a" && lc[1] == "l" && lc[2] == "b" &&
                 lc[3] == "u" && lc[4] == "m") begin
      hit_tag  = TagAlbum;
      hit_skip = 3'd6;
    end else if (len_e > 32'd5 && lc[0] == "d" && lc[1] == "a" && lc[2] == "t" &&
                 lc[3] == "e") begin
      hit_tag  = TagDate;
      hit_skip = 3'd5;
    end else begin
      hit = 1'b0;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = ph_e;
    unique case (ph_e)
      PhVlen: begin
        if (len_done) phase_d = (len_word == 32'd0) ? PhCount : PhVskip;
      end
      PhVskip: begin
        if (body_last) phase_d = PhCount;
      end
      PhCount: begin
        if (len_done) phase_d = (len_word == 32'd0) ? PhHalt : PhClen;
      end
      PhClen: begin
        if (len_done) begin
          if (guard_hit) phase_d = PhHalt;
          else if (len_word != 32'd0) phase_d = PhBody;
          else phase_d = last_comment ? PhHalt : PhClen;
        end
      end
      PhBody: begin
        if (body_last) phase_d = last_comment ? PhHalt : PhClen;
      end
      PhHalt: phase_d = PhHalt;
      default: phase_d = PhHalt;
    endcase
  end

  // Datapath updates and the records this byte causes.
  always_comb begin
    idx_d     = idx_e;
    len_d     = len_e;
    cnt_d     = cnt_e;
    body_d    = body_e;
    prefix_d  = prefix_e;
    pos_d     = pos_e;
    space_d   = space_e;
    wptr_d    = wptr_e;
    cstart_d  = cstart_e;
    storing_d = storing_e;
    closing   = 1'b0;
    wr_v      = 1'b0;
    fin_v     = 1'b0;
    tail_v    = 1'b0;
    wr_rec    = '0;
    fin_rec   = '0;
    tail_rec  = '0;

    unique case (ph_e)
      PhVlen, PhCount, PhClen: begin
        if (!len_done) begin
          idx_d = idx_e + 2'd1;
          len_d = len_word;
        end else begin
          idx_d = '0;
          len_d = '0;
          if (ph_e == PhVlen) begin
            if (len_word != 32'd0) body_d = len_word;
          end else if (ph_e == PhCount) begin
            cnt_d = len_word;
            if (len_word == 32'd0) begin
              tail_v        = 1'b1;
              tail_rec.kind = KindDone;
            end
          end else if (guard_hit) begin
            tail_v        = 1'b1;
            tail_rec.kind = KindError;
          end else begin
            len_d     = len_word;
            body_d    = len_word;
            prefix_d  = '0;
            pos_d     = '0;
            cstart_d  = wptr_e;
            storing_d = fits;
            if (fits) space_d = space_e - len_word[SpaceW-1:0];
            if (len_word == 32'd0) begin
              // An empty comment never matches: its zero bytes go back at once.
              closing      = 1'b1;
              fin_v        = 1'b1;
              fin_rec.kind = KindSpace;
              fin_rec.addr = wptr_e;
            end
          end
        end
      end
      PhVskip: begin
        body_d = body_e - 32'd1;
      end
      PhBody: begin
        body_d = body_e - 32'd1;
        if (storing_e) begin
          wr_v        = 1'b1;
          wr_rec.kind = KindWrite;
          wr_rec.addr = wptr_e;
          wr_rec.data = byte_in_i.byte_value;
          wptr_d      = wptr_e + AddrW'(1);
          if (pos_e < 3'd6) begin
            prefix_d[pos_e] = byte_in_i.byte_value;
            pos_d           = pos_e + 3'd1;
          end
        end
        if (body_last) begin
          closing = 1'b1;
          if (storing_e) begin
            fin_v        = 1'b1;
            fin_rec.addr = cstart_e;
            if (hit) begin
              fin_rec.kind = KindTag;
              fin_rec.tag  = hit_tag;
              fin_rec.voff = cstart_e + AddrW'(hit_skip);
              fin_rec.vlen = len_e[SpaceW-1:0] - SpaceW'(hit_skip);
            end else begin
              fin_rec.kind = KindSpace;
              fin_rec.vlen = len_e[SpaceW-1:0];
              space_d      = space_e + len_e[SpaceW-1:0];
              wptr_d       = cstart_e;
            end
          end
        end
      end
      PhHalt: ;
      default: ;
    endcase

    if (closing) begin
      storing_d = 1'b0;
      len_d     = '0;
      cnt_d     = cnt_e - 32'd1;
      if (last_comment) begin
        tail_v        = 1'b1;
        tail_rec.kind = KindDone;
      end
    end
  end

  // Pack the records in order: buffer write, comment close, header end.
  always_comb begin
    bundle_o = '0;
    n_slot   = '0;
    if (wr_v) begin
      bundle_o.rec[n_slot] = wr_rec;
      n_slot               = n_slot + 2'd1;
    end
    if (fin_v) begin
      bundle_o.rec[n_slot] = fin_rec;
      n_slot               = n_slot + 2'd1;
    end
    if (tail_v) begin
      bundle_o.rec[n_slot] = tail_rec;
      n_slot               = n_slot + 2'd1;
    end
    bundle_o.count = n_slot;
  end

  assign push_o = acc && (bundle_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhVlen;
      idx_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      body_q    <= '0;
      prefix_q  <= '0;
      pos_q     <= '0;
      space_q   <= SpaceW'(BufBytes);
      wptr_q    <= '0;
      cstart_q  <= '0;
      storing_q <= 1'b0;
    end else if (acc) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      body_q    <= body_d;
      prefix_q  <= prefix_d;
      pos_q     <= pos_d;
      space_q   <= space_d;
      wptr_q    <= wptr_d;
      cstart_q  <= cstart_d;
      storing_q <= storing_d;
    end
  end

endmodule

// ===== src/vctp_queue.sv =====
// Short queue of result bundles between the front end and the back end.
module vctp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vctp_pkg::bundle_t bundle_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output vctp_pkg::bundle_t head_o
);
  import vctp_pkg::*;

  bundle_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPtrW + 1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  assign wr_d  = push_i ? wr_q + QPtrW'(1) : wr_q;
  assign rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
  assign cnt_d = cnt_q + (QPtrW + 1)'(push_i) - (QPtrW + 1)'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/vctp_back.sv =====
// Back end: sends the records of the head bundle one transaction at a time.
module vctp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  vctp_pkg::bundle_t head_i,
  output logic              pop_o,
  vctp_rec_if.source        rec_out_o
);
  import vctp_pkg::*;

  logic [1:0] sub_q, sub_d;
  record_t    cur;
  logic       is_last, fire;

  assign cur     = head_i.rec[sub_q];
  assign is_last = sub_q == (head_i.count - 2'd1);

  assign rec_out_o.valid          = !empty_i;
  assign rec_out_o.record_kind    = cur.kind;
  assign rec_out_o.buffer_address = cur.addr;
  assign rec_out_o.data_byte      = cur.data;
  assign rec_out_o.tag_id         = cur.tag;
  assign rec_out_o.value_offset   = cur.voff;
  assign rec_out_o.value_length   = cur.vlen;
  assign rec_out_o.last           = is_last;

  assign fire  = rec_out_o.valid && rec_out_o.ready;
  assign pop_o = fire && is_last;
  assign sub_d = fire ? (is_last ? 2'd0 : sub_q + 2'd1) : sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

// ===== src/vorbis_comment_tag_parser.sv =====
// Top level of the Vorbis comment tag parser: register port, front end, queue, back end.
//
//   Channel     Direction  Payload                                        Handshake
//   byte_in_i   in         byte_value, start_req                          valid/ready
//   rec_out_o   out        record_kind, buffer_address, data_byte,        valid/ready
//                          tag_id, value_offset, value_length, last
//   APB         in/out     buffer_capacity, guard_enable, guard_length    psel/penable
//
// The front end takes header bytes back to back while the bundle queue is not full.
// A byte makes zero to three result records; the output sends one record per cycle
// while output ready is high, so one byte can hold the output for up to three records.
// A four-entry bundle queue sits between the two sides; input ready drops only while
// it is full, and it never depends combinationally on output ready.
// Reset is asynchronous and active low; it restores the register defaults and leaves
// the parser waiting for a vendor length with the full 4096-byte buffer free.
module vorbis_comment_tag_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  vctp_byte_if.sink   byte_in_i,
  vctp_rec_if.source  rec_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vctp_pkg::*;

  logic [SpaceW-1:0] cap_q;
  logic              guard_en_q;
  logic [31:0]       guard_len_q;
  logic              cfg_wr;
  cfg_t              cfg;
  logic              q_full, q_empty, push, pop;
  bundle_t           push_bundle, head;

  // Register port: every transaction completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= SpaceW'(BufBytes);
      guard_en_q  <= 1'b0;
      guard_len_q <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegBufCap:   cap_q       <= pwdata[SpaceW-1:0];
        RegGuardEn:  guard_en_q  <= pwdata[0];
        RegGuardLen: guard_len_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBufCap:   prdata = 32'(cap_q);
      RegGuardEn:  prdata = 32'(guard_en_q);
      RegGuardLen: prdata = guard_len_q;
      default:     prdata = '0;
    endcase
  end

  // The buffer capacity is clipped to the physical buffer size; the front end
  // loads it into its free-space count at every start request.
  assign cfg.cap_sat   = (cap_q > SpaceW'(BufBytes)) ? SpaceW'(BufBytes) : cap_q;
  assign cfg.guard_en  = guard_en_q;
  assign cfg.guard_len = guard_len_q;

  vctp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_in_i),
    .cfg_i     (cfg),
    .q_full_i  (q_full),
    .push_o    (push),
    .bundle_o  (push_bundle)
  );

  vctp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .full_o   (q_full),
    .pop_i    (pop),
    .empty_o  (q_empty),
    .head_o   (head)
  );

  vctp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .rec_out_o (rec_out_o)
  );

endmodule

// ===== src/vctp_checker.sv =====
// Port-level assertions for the Vorbis comment tag parser and their bind.
module vctp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [2:0]                  kind_i,
  input logic [vctp_pkg::AddrW-1:0]  addr_i,
  input logic [7:0]                  data_i,
  input logic [2:0]                  tag_i,
  input logic [vctp_pkg::AddrW-1:0]  voff_i,
  input logic [vctp_pkg::SpaceW-1:0] vlen_i,
  input logic                        last_i
);
  import vctp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({kind_i, addr_i, data_i, tag_i, voff_i, vlen_i, last_i}))
    else $error("stalled result transaction changed");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an accepted byte");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KindError || kind_i == KindDone) |-> last_i)
    else $error("error or done record not final for its byte");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindWrite |->
      tag_i == 3'd0 && voff_i == '0 && vlen_i == '0)
    else $error("buffer write carries tag fields");

endmodule

bind vorbis_comment_tag_parser vctp_checker u_vctp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_in_i.valid),
  .in_ready_i  (byte_in_i.ready),
  .out_valid_i (rec_out_o.valid),
  .out_ready_i (rec_out_o.ready),
  .kind_i      (rec_out_o.record_kind),
  .addr_i      (rec_out_o.buffer_address),
  .data_i      (rec_out_o.data_byte),
  .tag_i       (rec_out_o.tag_id),
  .voff_i      (rec_out_o.value_offset),
  .vlen_i      (rec_out_o.value_length),
  .last_i      (rec_out_o.last)
);
